// ===== hw/rtl/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Command framer and classifier package
// Shared constants, the command name table, the frame and result records,
// and the table lookup used by the back end.
// ----------------------------------------------------------------------------
package cfc_pkg;

   // Default frame limit in bytes; a frame that reaches it without ';' is dropped.
   localparam int FRAME_LIMIT_DEFAULT = 128;

   // Number of entries in the command table.
   localparam int CMD_COUNT = 25;

   // Depth of the queue between the framer and the classifier (a power of two).
   localparam int QUEUE_DEPTH = 2;

   // Frame terminator character.
   localparam logic [7:0] TERMINATOR = 8'h3B;

   // Result status codes.
   localparam logic [1:0] STATUS_WRITE   = 2'd0;
   localparam logic [1:0] STATUS_READ    = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   // One table entry: two name letters, the write length and the read length.
   // A length of zero marks a form that the command does not have.
   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
      logic [7:0] write_len;
      logic [7:0] query_len;
   } cmd_entry_type;

   localparam cmd_entry_type CMD_TABLE [CMD_COUNT] = '{
      '{"A", "G", 8'd7,  8'd4},
      '{"A", "I", 8'd4,  8'd3},
      '{"B", "D", 8'd3,  8'd0},
      '{"B", "U", 8'd3,  8'd0},
      '{"D", "B", 8'd7,  8'd3},
      '{"F", "A", 8'd14, 8'd3},
      '{"F", "B", 8'd14, 8'd3},
      '{"F", "R", 8'd4,  8'd3},
      '{"F", "T", 8'd4,  8'd3},
      '{"F", "W", 8'd7,  8'd7},
      '{"I", "D", 8'd0,  8'd3},
      '{"I", "F", 8'd0,  8'd3},
      '{"K", "S", 8'd4,  8'd3},
      '{"M", "D", 8'd4,  8'd3},
      '{"M", "G", 8'd6,  8'd3},
      '{"N", "R", 8'd4,  8'd3},
      '{"N", "T", 8'd4,  8'd3},
      '{"P", "C", 8'd6,  8'd3},
      '{"P", "D", 8'd0,  8'd3},
      '{"P", "S", 8'd4,  8'd3},
      '{"R", "X", 8'd3,  8'd0},
      '{"T", "X", 8'd3,  8'd0},
      '{"V", "X", 8'd4,  8'd3},
      '{"E", "D", 8'd0,  8'd3},
      '{"P", "R", 8'd0,  8'd3}
   };

   // A completed frame as handed from the framer to the classifier.
   // length holds the low eight bits of the frame length; length_wide is set
   // when the full length does not fit in eight bits.
   typedef struct packed {
      logic [7:0] name0;
      logic [7:0] name1;
      logic [7:0] length;
      logic       length_wide;
   } frame_type;

   // One result beat.
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] command_index;
      logic [7:0] frame_length;
   } result_type;

   // Compare the frame name against every table entry in parallel and grade
   // the length. The write form wins when both lengths are equal.
   function automatic result_type classify(frame_type frame);
      result_type res;
      logic       hit;
      res.status        = STATUS_UNKNOWN;
      res.command_index = '0;
      res.frame_length  = frame.length;
      hit               = 1'b0;
      for (int i = 0; i < CMD_COUNT; i++) begin
         if (!hit && frame.name0 == CMD_TABLE[i].first &&
             frame.name1 == CMD_TABLE[i].second) begin
            hit               = 1'b1;
            res.command_index = 5'(i);
            if (!frame.length_wide && CMD_TABLE[i].write_len != 8'd0 &&
                frame.length == CMD_TABLE[i].write_len) begin
               res.status = STATUS_WRITE;
            end else if (!frame.length_wide && CMD_TABLE[i].query_len != 8'd0 &&
                         frame.length == CMD_TABLE[i].query_len) begin
               res.status = STATUS_READ;
            end else begin
               res.status = STATUS_BAD_LEN;
            end
         end
      end
      return res;
   endfunction

endpackage

// ===== hw/rtl/cfc_req_if.sv =====
// ----------------------------------------------------------------------------
// Command byte channel
// Valid/ready channel that carries one received character per beat.
// ----------------------------------------------------------------------------
interface cfc_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);

endinterface

// ===== hw/rtl/cfc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Classification result channel
// Valid/ready channel that carries one classified frame per beat.
// ----------------------------------------------------------------------------
interface cfc_rsp_if;

   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] command_index;
   logic [7:0] frame_length;

   modport source (output valid, output status, output command_index,
                   output frame_length, input ready);
   modport sink   (input valid, input status, input command_index,
                   input frame_length, output ready);

endinterface

// ===== hw/rtl/cfc_framer.sv =====
// ----------------------------------------------------------------------------
// Command framer
// Counts the bytes of the current frame, keeps its first two characters and
// pushes a frame record into the queue when the terminator arrives. A frame
// that reaches the limit without a terminator is cleared silently.
// ----------------------------------------------------------------------------
module cfc_framer #(
   parameter int FRAME_LIMIT = cfc_pkg::FRAME_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   cfc_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push,
   output cfc_pkg::frame_type push_frame
);

   localparam int PW = $clog2(FRAME_LIMIT);
   localparam int LW = PW + 1;

   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [7:0]    name0_ff;
   logic [7:0]    name0_in;
   logic [7:0]    name1_ff;
   logic [7:0]    name1_in;

   logic          accept;
   logic          is_term;
   logic [LW-1:0] len_w;
   logic [7:0]    name0_cur;
   logic [7:0]    name1_cur;
   logic          clear;

   // A byte is taken whenever the queue has room for a possible frame record.
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_term        = (req_chan.rx_byte == cfc_pkg::TERMINATOR);

   // Length of the frame including this byte.
   assign len_w = {1'b0, pos_ff} + LW'(1);

   // The first two bytes, including a terminator that lands there, form the name.
   assign name0_cur = (pos_ff == PW'(0)) ? req_chan.rx_byte : name0_ff;
   assign name1_cur = (pos_ff == PW'(1)) ? req_chan.rx_byte : name1_ff;

   // Frame record for the classifier.
   assign push                   = accept && is_term;
   assign push_frame.name0       = name0_cur;
   assign push_frame.name1       = name1_cur;
   assign push_frame.length      = 8'(len_w);
   assign push_frame.length_wide = (32'(len_w) > 32'd255);

   // The frame ends on a terminator or when it reaches the limit.
   assign clear = is_term || (len_w >= LW'(FRAME_LIMIT));

   always_comb begin
      pos_in   = pos_ff;
      name0_in = name0_ff;
      name1_in = name1_ff;
      if (accept) begin
         if (clear) begin
            pos_in   = '0;
            name0_in = '0;
            name1_in = '0;
         end else begin
            pos_in   = len_w[PW-1:0];
            name0_in = name0_cur;
            name1_in = name1_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         name0_ff <= '0;
         name1_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         name0_ff <= name0_in;
         name1_ff <= name1_in;
      end
   end

endmodule

// ===== hw/rtl/cfc_queue.sv =====
// ----------------------------------------------------------------------------
// Frame queue
// Short first-in first-out queue of frame records between the framer and
// the classifier, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module cfc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cfc_pkg::frame_type push_frame,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output cfc_pkg::frame_type head
);

   localparam int DEPTH = cfc_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   cfc_pkg::frame_type slot_ff [DEPTH];
   logic [AW-1:0]      wr_ptr_ff;
   logic [AW-1:0]      wr_ptr_in;
   logic [AW-1:0]      rd_ptr_ff;
   logic [AW-1:0]      rd_ptr_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and occupancy updates; the depth is a power of two so the
   // pointers wrap on their own.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Record storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

// ===== hw/rtl/cfc_classifier.sv =====
// ----------------------------------------------------------------------------
// Command classifier
// Looks the queued frame name up in the command table, grades the length and
// holds the result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module cfc_classifier (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cfc_pkg::frame_type head,
   output logic               pop,
   cfc_rsp_if.source          rsp_chan
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   cfc_pkg::result_type  result_ff;
   cfc_pkg::result_type  result_in;

   // Take the next frame whenever the output register is free or draining.
   assign pop       = head_valid && (!out_valid_ff || rsp_chan.ready);
   assign result_in = cfc_pkg::classify(head);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   // Result beat.
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = result_ff.status;
   assign rsp_chan.command_index = result_ff.command_index;
   assign rsp_chan.frame_length  = result_ff.frame_length;

endmodule

// ===== hw/rtl/cat_command_framer_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Command framer and classifier, top level
// Frames a stream of two-letter, ';'-terminated control commands and reports
// for each frame whether it is a write form, a read form, a wrong length or
// an unknown name.
// ----------------------------------------------------------------------------
// Usage:
// req_chan carries one received character per beat. A beat is accepted when
// valid and ready are both high. Every byte that is not ';' only advances the
// frame; a ';' closes the frame and yields exactly one beat on rsp_chan with
// status, command_index and frame_length. A frame that reaches FRAME_LIMIT
// bytes without ';' is dropped with no result.
// Throughput is one byte per cycle while the frame queue is not full.
// After the ';' beat is accepted, the frame record is written into the frame
// queue, is classified as it leaves, and then sits in the output register,
// where the result beat turns valid on rsp_chan.
// When rsp_chan stalls, the output register holds its beat and the frame
// queue keeps up to two more records; req_chan.ready drops only while the
// queue is full. Reset clears the frame count, the name characters, the
// queue and the output valid; ready is high as soon as reset is released.
// ----------------------------------------------------------------------------
module cat_command_framer_classifier_top #(
   parameter int FRAME_LIMIT = cfc_pkg::FRAME_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cfc_req_if.sink     req_chan,
   cfc_rsp_if.source   rsp_chan
);

   logic               push;
   cfc_pkg::frame_type push_frame;
   logic               pop;
   logic               queue_full;
   logic               queue_not_empty;
   cfc_pkg::frame_type queue_head;

   // Front end: byte framing.
   cfc_framer #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_frame (push_frame)
   );

   // Queue of completed frames.
   cfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // Back end: table lookup and result register.
   cfc_classifier u_classifier (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head       (queue_head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

`ifndef SYNTHESIS
   // An unknown name always reports index zero.
   a_unknown_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == cfc_pkg::STATUS_UNKNOWN) |->
      (rsp_chan.command_index == 5'd0))
      else $error("unknown command reported with a nonzero index");

   // The input side only stalls while a result is waiting at the output.
   a_stall_implies_output: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with no result pending");

   // An accepted terminator beat is followed by a valid result beat at the output.
   a_term_reaches_output: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.rx_byte == cfc_pkg::TERMINATOR)
      |=> ##1 rsp_chan.valid)
      else $error("terminated frame did not reach the output");
`endif

endmodule
